### hdl/kswi_pkg.sv
// Package for the k-smallest-with-index block.
// Shared constants, defaults and the control struct used by kswi_list and kswi_drain.
package kswi_pkg;

    localparam int VALUE_BITS         = 32;
    localparam int KEEP_COUNT_BITS    = 4;
    localparam int OUT_POS_BITS       = 16;
    localparam int MAX_KEEP_DEFAULT   = 8;
    localparam int POSITION_BITS_DEFAULT = 16;

    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};

    typedef struct packed {
        logic advance;
        logic frame_end;
    } kswi_ctl_t;

endpackage

### hdl/kswi_list.sv
// Sorted list of the smallest samples with their frame positions.
// Inserts one sample per transfer; clears on frame end. Depends on kswi_pkg.
module kswi_list #(
    parameter int MAX_KEEP      = kswi_pkg::MAX_KEEP_DEFAULT,
    parameter int POSITION_BITS = kswi_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  kswi_pkg::kswi_ctl_t                         ctl,
    input  logic signed [kswi_pkg::VALUE_BITS-1:0]      sample_value,
    output logic signed [kswi_pkg::VALUE_BITS-1:0]      ins_value [MAX_KEEP],
    output logic        [POSITION_BITS-1:0]             ins_pos   [MAX_KEEP],
    output logic                                        ins_fill  [MAX_KEEP]
);
    import kswi_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic signed [VALUE_BITS-1:0] value_reg [MAX_KEEP];
    logic [POSITION_BITS-1:0]     pos_reg   [MAX_KEEP];
    logic                         fill_reg  [MAX_KEEP];
    logic [POSITION_BITS-1:0]     sample_pos_reg;
    logic [POSITION_BITS-1:0]     sample_pos_next;
    logic [MAX_KEEP-1:0]          hit;

    // hit is monotone: filled slots are sorted and empty slots trail
    always_comb begin
        for (int i = 0; i < MAX_KEEP; i++) begin
            hit[i] = !fill_reg[i] || (sample_value < value_reg[i]);
        end
        for (int i = 0; i < MAX_KEEP; i++) begin
            if (i > 0 && hit[i-1]) begin
                ins_value[i] = value_reg[i-1];
                ins_pos[i]   = pos_reg[i-1];
                ins_fill[i]  = fill_reg[i-1];
            end else if (hit[i]) begin
                ins_value[i] = sample_value;
                ins_pos[i]   = sample_pos_reg;
                ins_fill[i]  = 1'b1;
            end else begin
                ins_value[i] = value_reg[i];
                ins_pos[i]   = pos_reg[i];
                ins_fill[i]  = fill_reg[i];
            end
        end
        sample_pos_next = (sample_pos_reg == POS_MAX) ? sample_pos_reg
                                                      : sample_pos_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_pos_reg <= '0;
            for (int i = 0; i < MAX_KEEP; i++) begin
                value_reg[i] <= VALUE_MAX_POS;
                pos_reg[i]   <= '0;
                fill_reg[i]  <= 1'b0;
            end
        end else if (ctl.advance) begin
            if (ctl.frame_end) begin
                sample_pos_reg <= '0;
                for (int i = 0; i < MAX_KEEP; i++) begin
                    value_reg[i] <= VALUE_MAX_POS;
                    pos_reg[i]   <= '0;
                    fill_reg[i]  <= 1'b0;
                end
            end else begin
                sample_pos_reg <= sample_pos_next;
                for (int i = 0; i < MAX_KEEP; i++) begin
                    value_reg[i] <= ins_value[i];
                    pos_reg[i]   <= ins_pos[i];
                    fill_reg[i]  <= ins_fill[i];
                end
            end
        end
    end

endmodule

### hdl/kswi_drain.sv
// Frame-end snapshot buffer and result output register.
// Shifts out keep_count entries (0 gives 1, capped at MAX_KEEP), one per transfer. Depends on kswi_pkg.
module kswi_drain #(
    parameter int MAX_KEEP      = kswi_pkg::MAX_KEEP_DEFAULT,
    parameter int POSITION_BITS = kswi_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  kswi_pkg::kswi_ctl_t                         ctl,
    input  logic [kswi_pkg::KEEP_COUNT_BITS-1:0]        keep_count,
    input  logic signed [kswi_pkg::VALUE_BITS-1:0]      ins_value [MAX_KEEP],
    input  logic        [POSITION_BITS-1:0]             ins_pos   [MAX_KEEP],
    input  logic                                        ins_fill  [MAX_KEEP],
    output logic                                        busy,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic signed [kswi_pkg::VALUE_BITS-1:0]      m_min_value,
    output logic        [kswi_pkg::OUT_POS_BITS-1:0]    m_min_position,
    output logic                                        m_slot_filled,
    output logic                                        m_last_of_list
);
    import kswi_pkg::*;

    localparam int CNT_W = $clog2(MAX_KEEP + 1);

    logic signed [VALUE_BITS-1:0] buf_value_reg [MAX_KEEP];
    logic [POSITION_BITS-1:0]     buf_pos_reg   [MAX_KEEP];
    logic                         buf_fill_reg  [MAX_KEEP];
    logic [CNT_W-1:0]             rem_reg;
    logic [CNT_W-1:0]             keep_eff;
    logic                         m_valid_reg;
    logic signed [VALUE_BITS-1:0] m_value_reg;
    logic [OUT_POS_BITS-1:0]      m_pos_reg;
    logic                         m_fill_reg;
    logic                         m_last_reg;
    logic                         take;
    logic [POSITION_BITS+OUT_POS_BITS-1:0] pos_ext;

    always_comb begin
        if (keep_count == '0) begin
            keep_eff = CNT_W'(1);
        end else if (int'(keep_count) > MAX_KEEP) begin
            keep_eff = CNT_W'(MAX_KEEP);
        end else begin
            keep_eff = CNT_W'(keep_count);
        end
        take    = (rem_reg != '0) && (!m_valid_reg || m_ready);
        pos_ext = {{OUT_POS_BITS{1'b0}}, buf_pos_reg[0]};
    end

    assign busy           = (rem_reg != '0);
    assign m_valid        = m_valid_reg;
    assign m_min_value    = m_value_reg;
    assign m_min_position = m_pos_reg;
    assign m_slot_filled  = m_fill_reg;
    assign m_last_of_list = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctl.advance && ctl.frame_end) begin
                rem_reg <= keep_eff;
            end else if (take) begin
                rem_reg <= rem_reg - 1'b1;
            end
            if (take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.advance && ctl.frame_end) begin
            for (int i = 0; i < MAX_KEEP; i++) begin
                buf_value_reg[i] <= ins_value[i];
                buf_pos_reg[i]   <= ins_pos[i];
                buf_fill_reg[i]  <= ins_fill[i];
            end
        end else if (take) begin
            for (int i = 0; i < MAX_KEEP - 1; i++) begin
                buf_value_reg[i] <= buf_value_reg[i+1];
                buf_pos_reg[i]   <= buf_pos_reg[i+1];
                buf_fill_reg[i]  <= buf_fill_reg[i+1];
            end
        end
        if (take) begin
            m_value_reg <= buf_value_reg[0];
            m_pos_reg   <= pos_ext[OUT_POS_BITS-1:0];
            m_fill_reg  <= buf_fill_reg[0];
            m_last_reg  <= (rem_reg == CNT_W'(1));
        end
    end

endmodule

### hdl/k_smallest_with_index.sv
// Top level of the k-smallest-with-index block: input register, keep_count register.
// Instantiates kswi_list and kswi_drain; depends on kswi_pkg.
//
//   channel | direction | ports
//   s_      | in        | s_valid, s_ready, s_sample_value, s_frame_end
//   m_      | out       | m_valid, m_ready, m_min_value, m_min_position, m_slot_filled,
//           |           | m_last_of_list
//   cfg_    | in        | cfg_valid, cfg_ready, cfg_data (keep_count)
//
// One sample per cycle unless a frame-end sample waits; a sample passes the input register
// into the sorted list. A frame-end sample yields keep_count results (0 gives 1, at most
// MAX_KEEP) via input register, drain buffer and output register, one per cycle while m_ready.
// A frame-end sample waits in the input register while the previous frame still drains.
// Reset (synchronous, aresetn low) empties the list and sets keep_count to 1.
module k_smallest_with_index #(
    parameter int MAX_KEEP      = kswi_pkg::MAX_KEEP_DEFAULT,
    parameter int POSITION_BITS = kswi_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic signed [kswi_pkg::VALUE_BITS-1:0]      s_sample_value,
    input  logic                                        s_frame_end,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic signed [kswi_pkg::VALUE_BITS-1:0]      m_min_value,
    output logic        [kswi_pkg::OUT_POS_BITS-1:0]    m_min_position,
    output logic                                        m_slot_filled,
    output logic                                        m_last_of_list,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [kswi_pkg::KEEP_COUNT_BITS-1:0]        cfg_data
);
    import kswi_pkg::*;

    logic                         in_valid_reg;
    logic signed [VALUE_BITS-1:0] in_value_reg;
    logic                         in_end_reg;
    logic [KEEP_COUNT_BITS-1:0]   keep_count_reg;
    logic                         busy;
    kswi_ctl_t                    ctl;

    logic signed [VALUE_BITS-1:0] ins_value [MAX_KEEP];
    logic [POSITION_BITS-1:0]     ins_pos   [MAX_KEEP];
    logic                         ins_fill  [MAX_KEEP];

    always_comb begin
        ctl.advance   = in_valid_reg && !(in_end_reg && busy);
        ctl.frame_end = in_end_reg;
    end

    assign s_ready   = !in_valid_reg || ctl.advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            keep_count_reg <= KEEP_COUNT_BITS'(1);
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (cfg_valid) begin
                keep_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_value_reg <= s_sample_value;
            in_end_reg   <= s_frame_end;
        end
    end

    kswi_list #(
        .MAX_KEEP      (MAX_KEEP),
        .POSITION_BITS (POSITION_BITS)
    ) u_list (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .sample_value (in_value_reg),
        .ins_value    (ins_value),
        .ins_pos      (ins_pos),
        .ins_fill     (ins_fill)
    );

    kswi_drain #(
        .MAX_KEEP      (MAX_KEEP),
        .POSITION_BITS (POSITION_BITS)
    ) u_drain (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .keep_count     (keep_count_reg),
        .ins_value      (ins_value),
        .ins_pos        (ins_pos),
        .ins_fill       (ins_fill),
        .busy           (busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_min_value    (m_min_value),
        .m_min_position (m_min_position),
        .m_slot_filled  (m_slot_filled),
        .m_last_of_list (m_last_of_list)
    );

endmodule
